>>> design/svd_pkg.sv
package svd_pkg;

  // Fixed field widths of the item channels.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 24;
  localparam int unsigned VecNumW = 16;
  localparam int unsigned OffsetW = 25;
  localparam int unsigned KindW   = 3;
  localparam int unsigned HdrIdxW = 3;

  // Default width of the stored sample count.
  localparam int unsigned CountBitsDefault = 24;

  // Register map: one register per 32-bit word.
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam logic [0:0]  RegCapacity = 1'b0;

  localparam logic [LenW-1:0] CapacityReset = 24'hFFFFFF;

  // Framing bytes.
  localparam logic [ByteW-1:0] SyncFirst    = 8'h55;
  localparam logic [ByteW-1:0] SyncSecond   = 8'hAA;
  localparam logic [ByteW-1:0] LastFlag     = 8'hFF;
  localparam logic [ByteW-1:0] TrailFirst   = 8'hAE;
  localparam logic [ByteW-1:0] TrailSecond  = 8'hEA;

  // Index of the flag byte, the last of the six header bytes.
  localparam logic [HdrIdxW-1:0] HdrLast = 3'd5;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_DATA    = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [KindW-1:0] {
    K_NONE     = 3'd0,
    K_DATA     = 3'd1,
    K_READY    = 3'd2,
    K_FINISHED = 3'd3,
    K_IDLE     = 3'd4,
    K_DROP     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ByteW-1:0]   data_byte;
    logic [OffsetW-1:0] byte_offset;
    logic [LenW-1:0]    vector_length;
    logic [VecNumW-1:0] vector_number;
    logic               last_vector;
  } result_t;

endpackage

>>> design/sample_vector_deframer_top.sv
// A result item is registered in the output register when its input item is accepted,
// or in the one-entry skid buffer while the output stalls. Throughput: one item per cycle
// while in_ready is high; the whole state update is a single pass of logic. While a result
// waits, one more item goes into the skid buffer; then in_ready stays low until it empties.
// Reset (rst, synchronous, active high) returns the deframer to hunting for sync,
// clears the header and counters, empties the output stages and sets capacity to its maximum.
module sample_vector_deframer_top #(
  parameter int unsigned COUNT_BITS = svd_pkg::CountBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input item channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [svd_pkg::ByteW-1:0]    rx_byte,
  // Result item channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [svd_pkg::KindW-1:0]    kind,
  output logic [svd_pkg::ByteW-1:0]    data_byte,
  output logic [svd_pkg::OffsetW-1:0]  byte_offset,
  output logic [svd_pkg::LenW-1:0]     vector_length,
  output logic [svd_pkg::VecNumW-1:0]  vector_number,
  output logic                         last_vector,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [svd_pkg::AddrW-1:0]    paddr,
  input  logic [svd_pkg::DataW-1:0]    pwdata,
  output logic [svd_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  // Configuration register.
  logic [svd_pkg::LenW-1:0] capacity;

  // Deframer state.
  svd_pkg::phase_t                 phase, phase_next;
  logic [svd_pkg::ByteW-1:0]       previous_byte, previous_byte_next;
  logic [svd_pkg::HdrIdxW-1:0]     header_index, header_index_next;
  logic [COUNT_BITS-1:0]           sample_count, sample_count_next;
  logic [svd_pkg::VecNumW-1:0]     vector_id, vector_id_next;
  logic                            final_flag, final_flag_next;
  logic [svd_pkg::OffsetW-1:0]     data_index, data_index_next;

  // Output register and skid buffer.
  svd_pkg::result_t result, result_next;
  svd_pkg::result_t out_reg, skid_reg;
  logic             skid_valid;

  logic accept;
  logic cfg_write;

  // Helpers for the data phase.
  logic [svd_pkg::LenW-1:0]    count_full;
  logic [svd_pkg::OffsetW-1:0] index_inc;
  logic [svd_pkg::OffsetW-1:0] cap_bytes;
  logic [svd_pkg::OffsetW-1:0] len_bytes;
  logic                        keep_prev;

  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register read mux.
  always_comb begin
    prdata = '0;
    if (paddr[svd_pkg::AddrW-1] == svd_pkg::RegCapacity) begin
      prdata = svd_pkg::DataW'(capacity);
    end
  end

  // Capacity register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= svd_pkg::CapacityReset;
    end else if (cfg_write && paddr[svd_pkg::AddrW-1] == svd_pkg::RegCapacity) begin
      capacity <= pwdata[svd_pkg::LenW-1:0];
    end
  end

  assign count_full = svd_pkg::LenW'(sample_count);
  assign index_inc  = data_index + 1'b1;
  assign cap_bytes  = {capacity, 1'b0};
  assign len_bytes  = {count_full, 1'b0};

  // Next state and result for one input item.
  always_comb begin
    logic [svd_pkg::LenW-1:0] count_new;
    count_new          = count_full;
    phase_next         = phase;
    previous_byte_next = previous_byte;
    header_index_next  = header_index;
    vector_id_next     = vector_id;
    final_flag_next    = final_flag;
    data_index_next    = data_index;
    keep_prev          = 1'b0;
    result_next        = '0;
    result_next.kind   = svd_pkg::K_NONE;

    if (action) begin
      // Arm: restart the hunt, previous byte is kept.
      phase_next = svd_pkg::PH_HUNT;
      keep_prev  = 1'b1;
    end else begin
      unique case (phase)
        svd_pkg::PH_HUNT: begin
          if (previous_byte == svd_pkg::SyncFirst && rx_byte == svd_pkg::SyncSecond) begin
            phase_next        = svd_pkg::PH_HEADER;
            header_index_next = '0;
            keep_prev         = 1'b1;
          end
        end
        svd_pkg::PH_HEADER: begin
          // Little-endian count and vector number, then the flag byte.
          case (header_index)
            3'd0:    count_new[7:0]      = rx_byte;
            3'd1:    count_new[15:8]     = rx_byte;
            3'd2:    count_new[23:16]    = rx_byte;
            3'd3:    vector_id_next[7:0]  = rx_byte;
            3'd4:    vector_id_next[15:8] = rx_byte;
            default: final_flag_next     = (rx_byte == svd_pkg::LastFlag);
          endcase
          if (header_index >= svd_pkg::HdrLast) begin
            header_index_next = '0;
            data_index_next   = '0;
            phase_next        = svd_pkg::PH_DATA;
            keep_prev         = 1'b1;
          end else begin
            header_index_next = header_index + 1'b1;
          end
        end
        svd_pkg::PH_DATA: begin
          result_next.data_byte   = rx_byte;
          result_next.byte_offset = data_index;
          result_next.kind = (data_index < cap_bytes) ? svd_pkg::K_DATA : svd_pkg::K_DROP;
          data_index_next  = index_inc;
          // A zero count still ends after one byte.
          if (index_inc >= len_bytes) begin
            phase_next = svd_pkg::PH_TRAILER;
          end
        end
        svd_pkg::PH_TRAILER: begin
          if (previous_byte == svd_pkg::TrailFirst && rx_byte == svd_pkg::TrailSecond) begin
            keep_prev = 1'b1;
            if (final_flag) begin
              result_next.kind = svd_pkg::K_FINISHED;
              phase_next       = svd_pkg::PH_DONE;
            end else begin
              result_next.kind = svd_pkg::K_READY;
              phase_next       = svd_pkg::PH_HUNT;
            end
          end
        end
        default: begin
          // Recording finished: report idle and change nothing.
          result_next.kind = svd_pkg::K_IDLE;
          phase_next       = svd_pkg::PH_DONE;
          keep_prev        = 1'b1;
        end
      endcase
      if (!keep_prev) begin
        previous_byte_next = rx_byte;
      end
    end

    sample_count_next         = count_new[COUNT_BITS-1:0];
    result_next.vector_length = svd_pkg::LenW'(sample_count_next);
    result_next.vector_number = vector_id_next;
    result_next.last_vector   = final_flag_next;
  end

  assign result = result_next;

  // Deframer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= svd_pkg::PH_HUNT;
      previous_byte <= '0;
      header_index  <= '0;
      sample_count  <= '0;
      vector_id     <= '0;
      final_flag    <= 1'b0;
      data_index    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      previous_byte <= previous_byte_next;
      header_index  <= header_index_next;
      sample_count  <= sample_count_next;
      vector_id     <= vector_id_next;
      final_flag    <= final_flag_next;
      data_index    <= data_index_next;
    end
  end

  // Output register with a one-entry skid buffer behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload of the output stages.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (accept) begin
        out_reg <= result;
      end
    end else if (accept) begin
      skid_reg <= result;
    end
  end

  assign kind          = out_reg.kind;
  assign data_byte     = out_reg.data_byte;
  assign byte_offset   = out_reg.byte_offset;
  assign vector_length = out_reg.vector_length;
  assign vector_number = out_reg.vector_number;
  assign last_vector   = out_reg.last_vector;

endmodule
